// ===== design/assert_macros.svh =====
// assertion macros shared by the design files
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/wfpd_pkg.sv =====
// shared constants, types, state codes and constant tables of the peak detector
// no dependencies; used by the interfaces, the engine and the top level
package wfpd_pkg;

  localparam int SAMPLES  = 1024;
  localparam int LOG2N    = $clog2(SAMPLES);
  localparam int HALF     = SAMPLES / 2;
  localparam int SAMPLE_W = 16;
  localparam int WORK_W   = 20;
  localparam int MUL_W    = 2 * WORK_W;
  localparam int ACC_W    = MUL_W + 1;
  localparam int BIN_W    = 9;
  localparam int FREQ_W   = 17;
  localparam int RATE_W   = 18;
  localparam int STAGE_W  = $clog2(LOG2N);
  localparam int COEF_W   = 16;
  localparam int TW_AW    = LOG2N - 1;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LOG2N-1:0]           idx_t;
  typedef logic [BIN_W-1:0]           bin_t;
  typedef logic [FREQ_W-1:0]          freq_t;
  typedef logic [RATE_W-1:0]          rate_t;

  localparam rate_t RATE_RESET = RATE_W'(44100);

  // request codes
  localparam logic REQ_PUSH    = 1'b0;
  localparam logic REQ_ANALYZE = 1'b1;

  // register indexes
  localparam logic REG_SAMPLE_RATE = 1'b0;

  typedef enum logic [4:0] {
    E_IDLE,
    E_LD_RD, E_LD_MUL, E_LD_WR,
    E_BF_RD, E_BF_M0, E_BF_M1, E_BF_M2, E_BF_M3, E_BF_M4, E_BF_WA, E_BF_WB,
    E_PW_RD, E_PW_M0, E_PW_M1, E_PW_CMP,
    E_FQ_MUL, E_FQ_OUT
  } eng_state_t;

  typedef struct packed {
    logic start;
    idx_t base;
    logic full;
  } eng_req_t;

  typedef struct packed {
    logic  valid;
    bin_t  bin;
    freq_t freq;
  } eng_res_t;

  // fixed-point cosine tables, evaluated at elaboration
  localparam logic [63:0] Q30_ONE    = 64'd1073741824;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] RND30      = 64'd536870912;
  localparam logic [63:0] RND32      = 64'd2147483648;
  localparam logic [63:0] HANN_DEN   = 64'(SAMPLES - 1);

  typedef logic [COEF_W-1:0]   hann_rom_t [SAMPLES];
  typedef logic [2*COEF_W-1:0] tw_rom_t   [HALF];

  function automatic logic [63:0] to_rad(logic [63:0] a);
    return (a * TWO_PI_Q30 + RND32) >> 32;
  endfunction

  // cosine series in Q30, octant angle in Q32 turns
  function automatic longint series_cos(logic [63:0] a);
    logic [63:0] x, x2, t;
    longint sum;
    x   = to_rad(a);
    x2  = (x * x + RND30) >> 30;
    t   = Q30_ONE;
    sum = longint'(t);
    t = ((t * x2 + RND30) >> 30) / 64'd2;   sum = sum - longint'(t);
    t = ((t * x2 + RND30) >> 30) / 64'd12;  sum = sum + longint'(t);
    t = ((t * x2 + RND30) >> 30) / 64'd30;  sum = sum - longint'(t);
    t = ((t * x2 + RND30) >> 30) / 64'd56;  sum = sum + longint'(t);
    t = ((t * x2 + RND30) >> 30) / 64'd90;  sum = sum - longint'(t);
    t = ((t * x2 + RND30) >> 30) / 64'd132; sum = sum + longint'(t);
    return sum;
  endfunction

  // sine series in Q30
  function automatic longint series_sin(logic [63:0] a);
    logic [63:0] x, x2, t;
    longint sum;
    x   = to_rad(a);
    x2  = (x * x + RND30) >> 30;
    t   = x;
    sum = longint'(t);
    t = ((t * x2 + RND30) >> 30) / 64'd6;   sum = sum - longint'(t);
    t = ((t * x2 + RND30) >> 30) / 64'd20;  sum = sum + longint'(t);
    t = ((t * x2 + RND30) >> 30) / 64'd42;  sum = sum - longint'(t);
    t = ((t * x2 + RND30) >> 30) / 64'd72;  sum = sum + longint'(t);
    t = ((t * x2 + RND30) >> 30) / 64'd110; sum = sum - longint'(t);
    t = ((t * x2 + RND30) >> 30) / 64'd156; sum = sum + longint'(t);
    return sum;
  endfunction

  // cosine of a Q32 turn fraction, in Q30
  function automatic longint cos_frac(logic [63:0] f);
    logic [2:0]  k;
    logic [63:0] r, a;
    longint      res;
    k = f[31:29];
    r = f & 64'h1FFFFFFF;
    a = k[0] ? (64'h20000000 - r) : r;
    case (k)
      3'd0, 3'd7: res = series_cos(a);
      3'd1, 3'd6: res = series_sin(a);
      3'd2, 3'd5: res = -series_sin(a);
      default:    res = -series_cos(a);
    endcase
    return res;
  endfunction

  function automatic logic [COEF_W-1:0] sat_q15(longint v, longint lo);
    longint r;
    r = v;
    if (r > 32767) r = 32767;
    if (r < lo) r = lo;
    return COEF_W'(r);
  endfunction

  function automatic hann_rom_t build_hann();
    hann_rom_t   tab;
    logic [63:0] num;
    longint      c;
    for (int i = 0; i < SAMPLES; i++) begin
      num = 64'(i);
      if (num >= HANN_DEN) num = num - HANN_DEN;
      c = cos_frac((num << 32) / HANN_DEN);
      tab[i] = sat_q15((longint'(Q30_ONE) - c + 32768) >>> 16, 0);
    end
    return tab;
  endfunction

  // packed as cosine over sine
  function automatic tw_rom_t build_tw();
    tw_rom_t     tab;
    logic [63:0] num;
    longint      c, s;
    for (int i = 0; i < HALF; i++) begin
      c   = cos_frac(64'(i) << (32 - LOG2N));
      num = 64'(4 * i + 3 * SAMPLES);
      if (num >= 64'(4 * SAMPLES)) num = num - 64'(4 * SAMPLES);
      s   = cos_frac(num << (30 - LOG2N));
      tab[i] = {sat_q15((c + 16384) >>> 15, -32768), sat_q15((s + 16384) >>> 15, -32768)};
    end
    return tab;
  endfunction

  localparam hann_rom_t HANN_ROM = build_hann();
  localparam tw_rom_t   TW_ROM   = build_tw();

  function automatic idx_t bit_rev(idx_t v);
    idx_t r;
    for (int b = 0; b < LOG2N; b++) begin
      r[b] = v[LOG2N-1-b];
    end
    return r;
  endfunction

endpackage

// ===== design/wfpd_in_if.sv =====
// request channel of the peak detector: push a sample or ask for analysis
// depends on wfpd_pkg
interface wfpd_in_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  wfpd_pkg::sample_t sample;

  modport source (output valid, req_type, sample, input ready);
  modport sink (input valid, req_type, sample, output ready);
endinterface

// ===== design/wfpd_out_if.sv =====
// result channel of the peak detector: peak bin and its frequency
// depends on wfpd_pkg
interface wfpd_out_if;
  logic            valid;
  logic            ready;
  wfpd_pkg::bin_t  peak_bin;
  wfpd_pkg::freq_t peak_frequency;

  modport source (output valid, peak_bin, peak_frequency, input ready);
  modport sink (input valid, peak_bin, peak_frequency, output ready);
endinterface

// ===== design/wfpd_engine.sv =====
// analysis engine: window, radix-2 fft, power scan and bin-to-hertz conversion
// one shared multiplier under a sequencer; depends on wfpd_pkg
module wfpd_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  wfpd_pkg::eng_req_t req,
  output wfpd_pkg::idx_t     ring_addr,
  input  wfpd_pkg::sample_t  ring_q,
  input  wfpd_pkg::rate_t    rate,
  output wfpd_pkg::eng_res_t res,
  input  logic               take,
  output logic               idle
);
  import wfpd_pkg::*;

  eng_state_t state_r, state_nxt;
  idx_t       i_r, i_nxt;
  logic [STAGE_W-1:0] s_r, s_nxt;

  logic [2*WORK_W-1:0] work_mem [SAMPLES];
  logic [2*WORK_W-1:0] rda_r, rdb_r;
  logic [COEF_W-1:0]   hann_q_r;
  logic [2*COEF_W-1:0] tw_q_r;
  logic                ld_ok_r;

  logic signed [MUL_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [WORK_W-1:0] tr_r, ti_r;
  logic [ACC_W-1:0]         best_r;
  bin_t                     best_bin_r;

  logic signed [WORK_W-1:0] mul_a, mul_b;
  logic signed [WORK_W-1:0] ar, ai, br, bi, tc, ts;
  logic signed [ACC_W-1:0]  sum_ab, dif_ab, rnd_sum, rnd_dif, rnd_prod;
  logic signed [WORK_W:0]   h_rp, h_ip, h_rm, h_im;
  idx_t                     lomask, kk, ia, ib;
  logic [TW_AW-1:0]         jj, tw_addr;
  logic                     rd_en, wr_en;
  idx_t                     rd_a_addr, rd_b_addr, wr_addr;
  logic [2*WORK_W-1:0]      wr_data;

  // operand views
  assign ar = rda_r[2*WORK_W-1:WORK_W];
  assign ai = rda_r[WORK_W-1:0];
  assign br = rdb_r[2*WORK_W-1:WORK_W];
  assign bi = rdb_r[WORK_W-1:0];
  assign tc = WORK_W'($signed(tw_q_r[2*COEF_W-1:COEF_W]));
  assign ts = WORK_W'($signed(tw_q_r[COEF_W-1:0]));

  // butterfly addressing: insert a zero bit at the stage position
  assign kk      = {1'b0, i_r[LOG2N-2:0]};
  assign lomask  = ~({LOG2N{1'b1}} << s_r);
  assign ia      = ((kk & ~lomask) << 1) | (kk & lomask);
  assign ib      = ia | (idx_t'(1) << s_r);
  assign jj      = kk[TW_AW-1:0] & lomask[TW_AW-1:0];
  assign tw_addr = jj << (STAGE_W'(LOG2N - 1) - s_r);

  assign ring_addr = req.base + i_r;

  // shared multiplier
  assign prod_nxt = mul_a * mul_b;

  // rounding of sums of products to q15
  assign sum_ab   = acc_r + ACC_W'(prod_r);
  assign dif_ab   = acc_r - ACC_W'(prod_r);
  assign rnd_sum  = (sum_ab + ACC_W'(16384)) >>> 15;
  assign rnd_dif  = (dif_ab + ACC_W'(16384)) >>> 15;
  assign rnd_prod = (ACC_W'(prod_r) + ACC_W'(16384)) >>> 15;

  // halved butterfly outputs, rounded half up
  assign h_rp = ((WORK_W+1)'(ar) + (WORK_W+1)'(tr_r) + (WORK_W+1)'(1)) >>> 1;
  assign h_ip = ((WORK_W+1)'(ai) + (WORK_W+1)'(ti_r) + (WORK_W+1)'(1)) >>> 1;
  assign h_rm = ((WORK_W+1)'(ar) - (WORK_W+1)'(tr_r) + (WORK_W+1)'(1)) >>> 1;
  assign h_im = ((WORK_W+1)'(ai) - (WORK_W+1)'(ti_r) + (WORK_W+1)'(1)) >>> 1;

  // operand select, memory ports and result
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    rd_en     = 1'b0;
    rd_a_addr = ia;
    rd_b_addr = ib;
    wr_en     = 1'b0;
    wr_addr   = ia;
    wr_data   = {h_rp[WORK_W-1:0], h_ip[WORK_W-1:0]};
    case (state_r)
      E_LD_MUL: begin
        mul_a = ld_ok_r ? WORK_W'(ring_q) : '0;
        mul_b = WORK_W'(hann_q_r);
      end
      E_LD_WR: begin
        wr_en   = 1'b1;
        wr_addr = bit_rev(i_r);
        wr_data = {rnd_prod[WORK_W-1:0], {WORK_W{1'b0}}};
      end
      E_BF_RD: rd_en = 1'b1;
      E_BF_M0: begin mul_a = br; mul_b = tc; end
      E_BF_M1: begin mul_a = bi; mul_b = ts; end
      E_BF_M2: begin mul_a = bi; mul_b = tc; end
      E_BF_M3: begin mul_a = br; mul_b = ts; end
      E_BF_WA: wr_en = 1'b1;
      E_BF_WB: begin
        wr_en   = 1'b1;
        wr_addr = ib;
        wr_data = {h_rm[WORK_W-1:0], h_im[WORK_W-1:0]};
      end
      E_PW_RD: begin
        rd_en     = 1'b1;
        rd_a_addr = i_r;
      end
      E_PW_M0: begin mul_a = ar; mul_b = ar; end
      E_PW_M1: begin mul_a = ai; mul_b = ai; end
      // product held while the result waits to be taken
      E_FQ_MUL, E_FQ_OUT: begin
        mul_a = WORK_W'(rate);
        mul_b = WORK_W'(best_bin_r);
      end
      default: ;
    endcase
  end

  assign res.valid = (state_r == E_FQ_OUT);
  assign res.bin   = best_bin_r;
  assign res.freq  = prod_r[LOG2N +: FREQ_W];
  assign idle      = (state_r == E_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    s_nxt     = s_r;
    case (state_r)
      E_IDLE: begin
        if (req.start) begin
          state_nxt = E_LD_RD;
          i_nxt     = '0;
        end
      end
      E_LD_RD:  state_nxt = E_LD_MUL;
      E_LD_MUL: state_nxt = E_LD_WR;
      E_LD_WR: begin
        i_nxt = i_r + idx_t'(1);
        if (i_r == idx_t'(SAMPLES - 1)) begin
          state_nxt = E_BF_RD;
          s_nxt     = '0;
        end else begin
          state_nxt = E_LD_RD;
        end
      end
      E_BF_RD: state_nxt = E_BF_M0;
      E_BF_M0: state_nxt = E_BF_M1;
      E_BF_M1: state_nxt = E_BF_M2;
      E_BF_M2: state_nxt = E_BF_M3;
      E_BF_M3: state_nxt = E_BF_M4;
      E_BF_M4: state_nxt = E_BF_WA;
      E_BF_WA: state_nxt = E_BF_WB;
      E_BF_WB: begin
        i_nxt     = i_r + idx_t'(1);
        state_nxt = E_BF_RD;
        if (&i_r[LOG2N-2:0]) begin
          i_nxt = '0;
          if (s_r == STAGE_W'(LOG2N - 1)) begin
            state_nxt = E_PW_RD;
            i_nxt     = idx_t'(1);
          end else begin
            s_nxt = s_r + STAGE_W'(1);
          end
        end
      end
      E_PW_RD: state_nxt = E_PW_M0;
      E_PW_M0: state_nxt = E_PW_M1;
      E_PW_M1: state_nxt = E_PW_CMP;
      E_PW_CMP: begin
        i_nxt = i_r + idx_t'(1);
        if (i_r == idx_t'(HALF - 1)) begin
          state_nxt = E_FQ_MUL;
        end else begin
          state_nxt = E_PW_RD;
        end
      end
      E_FQ_MUL: state_nxt = E_FQ_OUT;
      E_FQ_OUT: begin
        if (take) begin
          state_nxt = E_IDLE;
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      i_r     <= '0;
      s_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      s_r     <= s_nxt;
    end
  end

  // work store and constant table reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      work_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rda_r <= work_mem[rd_a_addr];
      rdb_r <= work_mem[rd_b_addr];
    end
    hann_q_r <= HANN_ROM[i_r];
    tw_q_r   <= TW_ROM[tw_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    ld_ok_r <= req.full | (ring_addr < req.base);
    case (state_r)
      E_BF_M1, E_BF_M3, E_PW_M1: acc_r <= ACC_W'(prod_r);
      E_BF_M2: tr_r <= rnd_sum[WORK_W-1:0];
      E_BF_M4: ti_r <= rnd_dif[WORK_W-1:0];
      default: ;
    endcase
    if (req.start) begin
      best_r     <= '0;
      best_bin_r <= '0;
    end else if (state_r == E_PW_CMP && $unsigned(sum_ab) > best_r) begin
      best_r     <= sum_ab;
      best_bin_r <= i_r[BIN_W-1:0];
    end
  end

endmodule

// ===== design/windowed_fft_peak_detector.sv =====
// Hann-windowed fft peak detector. A push request stores one sample in a ring of the last
// 1024 samples. An analyze request windows the ring from oldest to newest, runs a 1024-point
// fixed-point fft that halves at every stage, scans bins 1 to 511 for the strongest power
// (first maximum wins, bin 0 if all are zero) and returns the bin and sample_rate*bin/1024 in
// hertz. The analysis time is set by the one shared multiplier and the single write port of
// the fft work store; no request is taken meanwhile, and a finished result waits in the output
// register without holding up further pushes. sample_rate sits at byte address 0.
// depends on wfpd_pkg, wfpd_in_if, wfpd_out_if, wfpd_engine and assert_macros.svh
`include "assert_macros.svh"

module windowed_fft_peak_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  wfpd_in_if.sink                       in_ch,
  wfpd_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wfpd_pkg::APB_AW-1:0]   paddr,
  input  logic [wfpd_pkg::APB_DW-1:0]   pwdata,
  output logic [wfpd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import wfpd_pkg::*;

  sample_t  ring_mem [SAMPLES];
  sample_t  ring_q_r;
  idx_t     ring_addr;
  idx_t     wp_r;
  logic     full_r;
  rate_t    rate_r;
  logic     out_valid_r;
  bin_t     out_bin_r;
  freq_t    out_freq_r;
  logic     eng_idle, in_acc, res_take, cfg_wr;
  eng_req_t req;
  eng_res_t res;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_SAMPLE_RATE);
  assign prdata = (paddr[2] == REG_SAMPLE_RATE) ? APB_DW'(rate_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
    end else if (cfg_wr) begin
      rate_r <= pwdata[RATE_W-1:0];
    end
  end

  // request transfer
  assign in_ch.ready = eng_idle;
  assign in_acc      = in_ch.valid & in_ch.ready;

  // sample ring: write pointer and wrap flag stand in for a cleared ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (in_acc && in_ch.req_type == REQ_PUSH) begin
      wp_r <= wp_r + idx_t'(1);
      if (&wp_r) begin
        full_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.req_type == REQ_PUSH) begin
      ring_mem[wp_r] <= in_ch.sample;
    end
    ring_q_r <= ring_mem[ring_addr];
  end

  assign req.start = in_acc & (in_ch.req_type == REQ_ANALYZE);
  assign req.base  = wp_r;
  assign req.full  = full_r;

  wfpd_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .ring_addr (ring_addr),
    .ring_q    (ring_q_r),
    .rate      (rate_r),
    .res       (res),
    .take      (res_take),
    .idle      (eng_idle)
  );

  // output register
  assign res_take = res.valid & (~out_valid_r | out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_bin_r  <= res.bin;
      out_freq_r <= res.freq;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.peak_bin       = out_bin_r;
  assign out_ch.peak_frequency = out_freq_r;

  // checks
  `ASSERT_CLK(a_out_from_engine, $rose(out_valid_r) |-> $past(res_take), "result without engine")
  `ASSERT_CLK(a_push_advances, in_acc && in_ch.req_type == REQ_PUSH |=> wp_r == $past(wp_r) + idx_t'(1), "push pointer slip")
  `ASSERT_CLK(a_analyze_keeps_ring, in_acc && in_ch.req_type == REQ_ANALYZE |=> wp_r == $past(wp_r), "analysis moved pointer")

endmodule
